>>> src/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// shared types and constants of the greedy b-colouring engine
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int MaxVertices = 64;
   localparam int VertexW     = 6;
   localparam int CountW      = 7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_G_RD,
      ST_G_EV,
      ST_G_AP,
      ST_R_INIT,
      ST_B_RD,
      ST_B_EV,
      ST_B_AP,
      ST_B_END,
      ST_D_RD,
      ST_D_EV,
      ST_D_AP,
      ST_D_END,
      ST_NEXT,
      ST_OUT
   } gbc_state_type;

   typedef struct packed {
      logic prep;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic used_ld;
      logic greedy_ap;
      logic move_ap;
      logic stuck_clr;
      logic cur_init;
      logic cur_dec;
      logic shift;
      logic out_ld;
      logic clear;
   } gbc_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic idx_coloured;
      logic cur_member;
      logic cc_zero;
      logic cur_zero;
      logic b_ok;
      logic stuck;
      logic out_ready;
   } gbc_sts_type;

endpackage

>>> src/gbc_ram.sv
// ----------------------------------------------------------------------------
// gbc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gbc_ram #(
   parameter int Width = 64,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/gbc_ctrl.sv
// ----------------------------------------------------------------------------
// gbc_ctrl
// sequencer for load, greedy fill, class reduction and report phases
// ----------------------------------------------------------------------------
module gbc_ctrl
   import gbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_accept,
   input  logic        req_last_vertex,
   input  gbc_sts_type sts,
   output gbc_cmd_type cmd,
   output logic        busy
);

   gbc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_last_vertex) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep    = 1'b1;
            cmd.idx_clr = 1'b1;
            state_in    = ST_G_RD;
         end
         ST_G_RD: begin
            if (sts.idx_coloured) begin
               if (sts.idx_last) state_in = ST_R_INIT;
               else cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_G_EV;
            end
         end
         ST_G_EV: begin
            cmd.used_ld = 1'b1;
            state_in    = ST_G_AP;
         end
         ST_G_AP: begin
            cmd.greedy_ap = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_R_INIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_G_RD;
            end
         end
         ST_R_INIT: begin
            cmd.idx_clr = 1'b1;
            if (sts.cc_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.cur_init = 1'b1;
               state_in     = ST_B_RD;
            end
         end
         ST_B_RD: begin
            if (!sts.cur_member) begin
               if (sts.idx_last) state_in = ST_B_END;
               else cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_B_EV;
            end
         end
         ST_B_EV: begin
            cmd.used_ld = 1'b1;
            state_in    = ST_B_AP;
         end
         ST_B_AP: begin
            if (sts.b_ok) begin
               state_in = ST_NEXT;
            end else if (sts.idx_last) begin
               state_in = ST_B_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_B_RD;
            end
         end
         ST_B_END: begin
            cmd.idx_clr   = 1'b1;
            cmd.stuck_clr = 1'b1;
            state_in      = ST_D_RD;
         end
         ST_D_RD: begin
            if (!sts.cur_member) begin
               if (sts.idx_last) state_in = ST_D_END;
               else cmd.idx_inc = 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_D_EV;
            end
         end
         ST_D_EV: begin
            cmd.used_ld = 1'b1;
            state_in    = ST_D_AP;
         end
         ST_D_AP: begin
            cmd.move_ap = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_D_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_D_RD;
            end
         end
         ST_D_END: begin
            cmd.shift = !sts.stuck;
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.idx_clr = 1'b1;
            if (sts.cur_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.cur_dec = 1'b1;
               state_in    = ST_B_RD;
            end
         end
         ST_OUT: begin
            if (sts.out_ready) begin
               cmd.out_ld = 1'b1;
               if (sts.idx_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> src/gbc_datapath.sv
// ----------------------------------------------------------------------------
// gbc_datapath
// adjacency ram, per-vertex colour cells, class count and result register
// ----------------------------------------------------------------------------
module gbc_datapath
   import gbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [CountW-1:0]  csr_vertex_count,
   input  logic               req_accept,
   input  logic [VertexW-1:0] req_vertex,
   input  logic [63:0]        req_neighbours,
   input  logic [CountW-1:0]  req_preset_colour,
   input  gbc_cmd_type        cmd,
   output gbc_sts_type        sts,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [VertexW-1:0] rsp_out_vertex,
   output logic [VertexW-1:0] rsp_colour,
   output logic [CountW-1:0]  rsp_colour_count,
   output logic               rsp_last_result
);

   logic [CountW-1:0]  vcount_ff;
   logic [CountW-1:0]  cc_ff;
   logic [VertexW-1:0] idx_ff;
   logic [VertexW-1:0] cur_ff;
   logic               stuck_ff;
   logic [63:0]        used_ff;
   logic [63:0]        colv_ff;
   logic [VertexW-1:0] col_ff [MaxVertices];

   logic               rsp_valid_ff;
   logic [VertexW-1:0] rsp_vertex_ff;
   logic [VertexW-1:0] rsp_colour_ff;
   logic [CountW-1:0]  rsp_count_ff;
   logic               rsp_last_ff;

   logic [CountW-1:0]  n_act;
   logic [VertexW-1:0] n_m1;
   logic [63:0]        vmask;
   logic [63:0]        ccmask;
   logic [63:0]        rd_row;
   logic [63:0]        nb;
   logic [63:0]        used_in;
   logic [63:0]        avail;
   logic [VertexW-1:0] first_free;
   logic               found;
   logic               load_ok;
   logic               preset_ok;

   // clamp vertex count into 1..MaxVertices
   always_comb begin
      if (vcount_ff == '0) n_act = CountW'(1);
      else if (vcount_ff > CountW'(MaxVertices)) n_act = CountW'(MaxVertices);
      else n_act = vcount_ff;
   end
   assign n_m1 = VertexW'(n_act - CountW'(1));

   always_comb begin
      for (int i = 0; i < MaxVertices; i++) begin
         vmask[i]  = (CountW'(i) < n_act);
         ccmask[i] = (CountW'(i) < cc_ff);
      end
   end

   assign load_ok   = req_accept && ({1'b0, req_vertex} < n_act);
   assign preset_ok = (req_preset_colour < CountW'(MaxVertices));

   gbc_ram #(
      .Width (64),
      .Depth (MaxVertices)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (req_vertex),
      .wr_data (req_neighbours),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_row)
   );

   // classes taken by neighbours of the row just read
   assign nb = rd_row & vmask;
   always_comb begin
      used_in = '0;
      for (int u = 0; u < MaxVertices; u++) begin
         if (nb[u] && colv_ff[u]) used_in = used_in | (64'd1 << col_ff[u]);
      end
   end

   // first free class below the count; in a move the dissolved one is excluded
   always_comb begin
      avail = ~used_ff & ccmask;
      if (cmd.move_ap) avail = avail & ~(64'd1 << cur_ff);
      found      = |avail;
      first_free = '0;
      for (int c = MaxVertices - 1; c >= 0; c--) begin
         if (avail[c]) first_free = VertexW'(c);
      end
   end

   always_comb begin
      sts.idx_last     = (idx_ff == n_m1);
      sts.idx_coloured = colv_ff[idx_ff];
      sts.cur_member   = colv_ff[idx_ff] && (col_ff[idx_ff] == cur_ff);
      sts.cc_zero      = (cc_ff == '0);
      sts.cur_zero     = (cur_ff == '0);
      sts.b_ok         = &(used_ff | ~ccmask | (64'd1 << cur_ff));
      sts.stuck        = stuck_ff;
      sts.out_ready    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= CountW'(MaxVertices);
         cc_ff        <= '0;
         idx_ff       <= '0;
         cur_ff       <= '0;
         stuck_ff     <= 1'b0;
         colv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) vcount_ff <= csr_vertex_count;

         if (load_ok) begin
            colv_ff[req_vertex] <= preset_ok;
            col_ff[req_vertex]  <= req_preset_colour[VertexW-1:0];
            if (preset_ok && (cc_ff < req_preset_colour + CountW'(1))) begin
               cc_ff <= req_preset_colour + CountW'(1);
            end
         end

         if (cmd.prep) colv_ff <= colv_ff & vmask;

         if (cmd.idx_clr) idx_ff <= '0;
         else if (cmd.idx_inc) idx_ff <= idx_ff + VertexW'(1);

         if (cmd.cur_init) cur_ff <= VertexW'(cc_ff - CountW'(1));
         else if (cmd.cur_dec) cur_ff <= cur_ff - VertexW'(1);

         if (cmd.used_ld) used_ff <= used_in;

         if (cmd.greedy_ap) begin
            if (found) begin
               col_ff[idx_ff]  <= first_free;
               colv_ff[idx_ff] <= 1'b1;
            end else if (cc_ff < CountW'(MaxVertices)) begin
               col_ff[idx_ff]  <= cc_ff[VertexW-1:0];
               colv_ff[idx_ff] <= 1'b1;
               cc_ff           <= cc_ff + CountW'(1);
            end
         end

         if (cmd.stuck_clr) stuck_ff <= 1'b0;
         if (cmd.move_ap) begin
            if (found) col_ff[idx_ff] <= first_free;
            else stuck_ff <= 1'b1;
         end

         // drop the empty class, higher classes move down one
         if (cmd.shift) begin
            for (int u = 0; u < MaxVertices; u++) begin
               if (colv_ff[u] && (col_ff[u] > cur_ff)) col_ff[u] <= col_ff[u] - VertexW'(1);
            end
            cc_ff <= cc_ff - CountW'(1);
         end

         if (cmd.out_ld) begin
            rsp_valid_ff  <= 1'b1;
            rsp_vertex_ff <= idx_ff;
            rsp_colour_ff <= colv_ff[idx_ff] ? col_ff[idx_ff] : '0;
            rsp_count_ff  <= cc_ff;
            rsp_last_ff   <= (idx_ff == n_m1);
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.clear) begin
            colv_ff <= '0;
            cc_ff   <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_vertex   = rsp_vertex_ff;
   assign rsp_colour       = rsp_colour_ff;
   assign rsp_colour_count = rsp_count_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

>>> src/greedy_b_colouring_engine_unit.sv
// ----------------------------------------------------------------------------
// greedy_b_colouring_engine_unit
// graph colouring: greedy completion then b-colouring class reduction
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | vertex, neighbours, preset, last
//  rsp     | out       | rsp_valid/stall    | vertex, colour, count, last
//  csr     | in        | csr_valid/ready    | vertex_count
//
//  rows load one per cycle while idle; the row marked last starts the run
//  greedy fill reads, evaluates and applies each uncoloured vertex, paced by the
//  registered read of the adjacency ram and a registered used-class vector
//  each class scan walks the vertices in order and reads, evaluates and applies
//  only the members of the class; a run ends with n reports
//  reset is synchronous; the colour cells clear at once, adjacency is kept
//  req_stall is high for the whole run; the report waits on rsp_stall
// ----------------------------------------------------------------------------
module greedy_b_colouring_engine_unit
   import gbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CountW-1:0]  csr_vertex_count,
   // row input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VertexW-1:0] req_vertex,
   input  logic [63:0]        req_neighbours,
   input  logic [CountW-1:0]  req_preset_colour,
   input  logic               req_last_vertex,
   // colour report
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VertexW-1:0] rsp_out_vertex,
   output logic [VertexW-1:0] rsp_colour,
   output logic [CountW-1:0]  rsp_colour_count,
   output logic               rsp_last_result
);

   gbc_cmd_type cmd;
   gbc_sts_type sts;
   logic        busy;
   logic        req_accept;

   // register writes are taken only while idle
   assign csr_ready  = !busy;
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;

   gbc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_accept),
      .req_last_vertex (req_last_vertex),
      .sts             (sts),
      .cmd             (cmd),
      .busy            (busy)
   );

   gbc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid && csr_ready),
      .csr_vertex_count  (csr_vertex_count),
      .req_accept        (req_accept),
      .req_vertex        (req_vertex),
      .req_neighbours    (req_neighbours),
      .req_preset_colour (req_preset_colour),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_vertex    (rsp_out_vertex),
      .rsp_colour        (rsp_colour),
      .rsp_colour_count  (rsp_colour_count),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

>>> tb/greedy_b_colouring_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// greedy_b_colouring_engine_unit_tb
// self-checking bench: rows and vertex counts go in, per-vertex colour reports
// are checked against an in-bench colouring predictor, with random gaps on
// both channels, a long report hold-off and several vertex count settings
// ----------------------------------------------------------------------------
module greedy_b_colouring_engine_unit_tb
   import gbc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit  = 150000;
   localparam int RandomRows = 180;
   localparam int HoldCycles = 300;

   typedef struct {
      logic [VertexW-1:0] vtx;
      logic [VertexW-1:0] colour;
      logic [CountW-1:0]  count;
      logic               last;
   } colour_report_type;

   // predictor of the colouring plus the queue of reports still owed
   class colouring_scoreboard;
      logic [63:0]       rows [64];
      logic [63:0]       classes [64];
      int                class_total;
      int                vcount;
      int                errors;
      colour_report_type owed [$];

      function new();
         class_total = 0;
         vcount      = MaxVertices;
         errors      = 0;
         foreach (classes[c]) classes[c] = '0;
         foreach (rows[c]) rows[c] = '0;
      endfunction

      // one accepted row; a last row runs the whole colouring
      function void note_row(logic [5:0] vtx, logic [63:0] nb, logic [6:0] preset,
                             logic last);
         int                n, cur, j, k, v, c, col;
         logic [63:0]       m, done, adj;
         bit                placed, bfound, ok;
         colour_report_type rep;
         n = (vcount < 1) ? 1 : ((vcount > MaxVertices) ? MaxVertices : vcount);
         m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
         if (vtx < n) begin
            rows[vtx] = nb;
            for (c = 0; c < 64; c++) classes[c][vtx] = 1'b0;
            if (preset < 64) begin
               classes[preset[5:0]][vtx] = 1'b1;
               if (class_total < preset + 1) class_total = preset + 1;
            end
         end
         if (!last) return;
         for (c = 0; c < 64; c++) classes[c] &= m;
         // greedy completion, lowest vertex first
         done = '0;
         for (c = 0; c < class_total; c++) done |= classes[c];
         for (v = 0; v < n; v++) begin
            if (done[v]) continue;
            adj    = rows[v] & m;
            placed = 0;
            for (c = 0; c < class_total && !placed; c++) begin
               if ((adj & classes[c]) == 0) begin
                  classes[c][v] = 1'b1;
                  placed = 1;
               end
            end
            if (!placed && class_total < 64) begin
               classes[class_total][v] = 1'b1;
               class_total++;
            end
            done[v] = 1'b1;
         end
         // dissolve classes without a b-vertex, highest first
         for (k = class_total; k > 0; k--) begin
            cur = k - 1;
            if (cur >= class_total) continue;
            bfound = 0;
            for (v = 0; v < n; v++) begin
               if (!classes[cur][v]) continue;
               adj = rows[v] & m;
               ok  = 1;
               for (j = 0; j < class_total; j++)
                  if (j != cur && (adj & classes[j]) == 0) ok = 0;
               if (ok) bfound = 1;
            end
            if (bfound) continue;
            for (v = 0; v < n; v++) begin
               if (!classes[cur][v]) continue;
               adj = rows[v] & m;
               for (j = 0; j < class_total; j++) begin
                  if (j != cur && (adj & classes[j]) == 0) begin
                     classes[j][v]   = 1'b1;
                     classes[cur][v] = 1'b0;
                     break;
                  end
               end
            end
            if (classes[cur] != 0) continue;
            for (j = cur; j + 1 < class_total; j++) classes[j] = classes[j+1];
            classes[class_total-1] = '0;
            class_total--;
         end
         for (v = 0; v < n; v++) begin
            col = 0;
            for (c = 0; c < class_total; c++) begin
               if (classes[c][v]) begin
                  col = c;
                  break;
               end
            end
            rep.vtx    = v[5:0];
            rep.colour = col[5:0];
            rep.count  = class_total[6:0];
            rep.last   = (v + 1 == n);
            owed.push_back(rep);
         end
         for (c = 0; c < 64; c++) classes[c] = '0;
         class_total = 0;
      endfunction

      function void check_report(colour_report_type got);
         colour_report_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected report vertex %0d colour %0d", $time,
                     got.vtx, got.colour);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.vtx !== want.vtx) begin
            $display("%0t: out_vertex expected %0d got %0d", $time, want.vtx, got.vtx);
            errors++;
         end
         if (got.colour !== want.colour) begin
            $display("%0t: colour of vertex %0d expected %0d got %0d", $time,
                     want.vtx, want.colour, got.colour);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: colour_count expected %0d got %0d", $time,
                     want.count, got.count);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_result of vertex %0d expected %0d got %0d", $time,
                     want.vtx, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [CountW-1:0]  csr_vertex_count;
   logic               req_valid;
   logic               req_stall;
   logic [VertexW-1:0] req_vertex;
   logic [63:0]        req_neighbours;
   logic [CountW-1:0]  req_preset_colour;
   logic               req_last_vertex;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [VertexW-1:0] rsp_out_vertex;
   logic [VertexW-1:0] rsp_colour;
   logic [CountW-1:0]  rsp_colour_count;
   logic               rsp_last_result;

   colouring_scoreboard sb;
   logic [63:0] rows_written;   // rows loaded at least once
   int          n_act;          // vertex count the block uses now
   int          rows_sent;      // in-range rows of the random part
   bit          quiet;          // no gaps on either side
   bit          hold_request;   // receiver holds off for a long stretch
   int          idle_cycles;
   colour_report_type seen;

   greedy_b_colouring_engine_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_vertex_count  (csr_vertex_count),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_vertex        (req_vertex),
      .req_neighbours    (req_neighbours),
      .req_preset_colour (req_preset_colour),
      .req_last_vertex   (req_last_vertex),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_vertex    (rsp_out_vertex),
      .rsp_colour        (rsp_colour),
      .rsp_colour_count  (rsp_colour_count),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // monitor: values read here are the ones present before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_row(req_vertex, req_neighbours, req_preset_colour, req_last_vertex);
         if (rsp_valid && !rsp_stall) begin
            seen.vtx    = rsp_out_vertex;
            seen.colour = rsp_colour;
            seen.count  = rsp_colour_count;
            seen.last   = rsp_last_result;
            sb.check_report(seen);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (quiet || r < 10) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] rand_row();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return {$urandom, $urandom};
         default: return {$urandom, $urandom} & {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [6:0] rand_preset();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 7'd64;
      if (r < 13) return 7'($urandom_range(0, 3));
      if (r == 13) return 7'($urandom_range(65, 127));
      return 7'($urandom_range(0, 63));
   endfunction

   // receiver: random stalls, a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      hold_request = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   // called right after a rising edge; returns after the transfer edge and any gap
   task automatic send_row(int vtx, logic [63:0] nb, logic [6:0] preset, bit last);
      int gap;
      req_valid         <= 1'b1;
      req_vertex        <= vtx[5:0];
      req_neighbours    <= nb;
      req_preset_colour <= preset;
      req_last_vertex   <= last;
      do @(posedge clock); while (req_stall);
      if (vtx < n_act) begin
         rows_written[vtx] = 1'b1;
         rows_sent++;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pause until every report is in, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.owed.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_count(int value);
      csr_valid        <= 1'b1;
      csr_vertex_count <= value[6:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.vcount = value;
      n_act = (value < 1) ? 1 : ((value > MaxVertices) ? MaxVertices : value);
   endtask

   // one colouring: unwritten rows always loaded, some rows reloaded,
   // optional rows outside the vertex count and an out-of-range last row
   task automatic colour_graph(int reloads, bit noisy);
      int order [$];
      int v, k;
      bit last_out;
      for (v = 0; v < n_act; v++)
         if (!rows_written[v] || $urandom_range(0, 2) == 0) order.push_back(v);
      repeat (reloads) order.push_back($urandom_range(0, n_act - 1));
      if (order.size() == 0) order.push_back($urandom_range(0, n_act - 1));
      last_out = noisy && n_act < MaxVertices && $urandom_range(0, 5) == 0;
      for (k = 0; k < order.size(); k++) begin
         if (noisy && n_act < MaxVertices && $urandom_range(0, 7) == 0)
            send_row($urandom_range(n_act, 63), rand_row(), rand_preset(), 1'b0);
         send_row(order[k], rand_row(), rand_preset(),
                  (k == order.size() - 1) && !last_out);
      end
      if (last_out)
         send_row($urandom_range(n_act, 63), rand_row(), rand_preset(), 1'b1);
   endtask

   initial begin
      int graph_no;
      int r;
      sb                = new();
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_vertex_count  = '0;
      req_valid         = 1'b0;
      req_vertex        = '0;
      req_neighbours    = '0;
      req_preset_colour = '0;
      req_last_vertex   = 1'b0;
      rows_written      = '0;
      n_act             = MaxVertices;
      quiet             = 0;
      idle_cycles       = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty graph, all uncoloured
      write_count(3);
      send_row(0, '0, 7'd64, 0);
      send_row(1, '0, 7'd64, 0);
      send_row(2, '0, 7'd64, 1);
      drain();
      // triangle with every vertex preset, then preset well above the graph
      send_row(0, 64'h6, 7'd0, 0);
      send_row(1, 64'h5, 7'd1, 0);
      send_row(2, 64'h3, 7'd2, 1);
      drain();
      send_row(1, 64'h5, 7'd63, 0);
      send_row(1, 64'h5, 7'd127, 0);     // reload drops the preset again
      send_row(2, '1, 7'd64, 1);
      drain();
      // count of zero acts as one; out-of-range rows ignored, last still runs
      write_count(0);
      send_row(9, '1, 7'd0, 0);
      send_row(0, '1, 7'd5, 0);
      send_row(40, '0, 7'd64, 1);
      drain();
      // stuck member: path 0-1-2 with 0 and 2 apart
      write_count(3);
      send_row(0, 64'h2, 7'd1, 0);
      send_row(1, 64'h5, 7'd64, 0);
      send_row(2, 64'h2, 7'd0, 1);
      drain();

      // random part: a full-size graph first loads every row not loaded before
      rows_sent = 0;
      graph_no  = 0;
      write_count(127);
      while (rows_sent < RandomRows) begin
         if (graph_no > 0 && graph_no % 2 == 0) begin
            drain();
            r = $urandom_range(0, 9);
            if (r == 0) write_count(64);
            else if (r == 1) write_count($urandom_range(65, 127));
            else write_count($urandom_range(1, 12));
         end
         quiet = (graph_no % 7 == 3);
         // report held back while the next graph keeps offering rows
         if (graph_no == 5) hold_request = 1;
         colour_graph($urandom_range(0, 2), 1);
         graph_no++;
      end
      quiet = 0;
      drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
src/gbc_pkg.sv
src/gbc_ram.sv
src/gbc_ctrl.sv
src/gbc_datapath.sv
src/greedy_b_colouring_engine_unit.sv
tb/greedy_b_colouring_engine_unit_tb.sv
